/* hw/rtl/line_sensor_pid_steering_macros.svh */
// Assertion macros for the line sensor PID steering block.
// Included by line_sensor_pid_steering.sv; expects clk and arst_n in scope.
`ifndef LINE_SENSOR_PID_STEERING_MACROS_SVH
`define LINE_SENSOR_PID_STEERING_MACROS_SVH

// same-cycle implication
`define LSPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lsps_pkg.sv */
// Package for the line sensor PID steering block: widths, defaults,
// register indexes, types and the sensor pattern decoder. No dependencies.
package lsps_pkg;

	localparam int DUTY_BITS_DEF = 10;
	localparam int SUM_BITS_DEF  = 16;

	localparam int PAT_W      = 5;
	localparam int ERR_W      = 4;
	localparam int GP_W       = 8;
	localparam int GI_W       = 16;
	localparam int GD_W       = 8;
	localparam int BASE_W     = 10;
	localparam int DRIVE_W    = 13;
	localparam int FRAC_BITS  = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DRIVE_MAX = 4095;
	localparam int DRIVE_MIN = -4096;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INT_Q24 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED   = 2'd3;

	localparam logic [GP_W-1:0]   GAIN_PROP_RST    = 8'd70;
	localparam logic [GI_W-1:0]   GAIN_INT_Q24_RST = 16'd923;
	localparam logic [GD_W-1:0]   GAIN_DERIV_RST   = 8'd100;
	localparam logic [BASE_W-1:0] BASE_SPEED_RST   = 10'd300;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic hit;
		err_t err;
	} pos_t;

	// bit0 = leftmost sensor, 1 = off the line
	function automatic pos_t decode_pattern(input logic [PAT_W-1:0] pat);
		pos_t r;
		r.hit = 1'b1;
		r.err = '0;
		case (pat)
			5'd15: r.err = 4'sd4;
			5'd7:  r.err = 4'sd3;
			5'd23: r.err = 4'sd2;
			5'd19: r.err = 4'sd1;
			5'd27: r.err = 4'sd0;
			5'd25: r.err = -4'sd1;
			5'd29: r.err = -4'sd2;
			5'd28: r.err = -4'sd3;
			5'd30: r.err = -4'sd4;
			default: begin
				r.hit = 1'b0;
				r.err = '0;
			end
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/line_sensor_pid_steering.sv */
// Line sensor PID steering controller, top level.
// Depends on lsps_pkg and line_sensor_pid_steering_macros.svh.
//
// channel  | handshake                   | payload
// ---------+-----------------------------+-----------------------------------------------
// input    | in_valid / in_stall         | sensor_pattern
// output   | out_valid / out_stall       | right_duty left_duty position_error
//          |                             | drive_value clamped
// config   | cfg_wr_en                   | cfg_index cfg_data
//
// One transaction per cycle sustained while out_stall is low; out_valid follows the input
// through the decode/integrate stage, multiply stage and sum/clamp output register.
// Reset restores the gain and base speed defaults and clears last error and integral.
// in_stall rises only when all three stages hold a transaction and out_stall is high.
`include "line_sensor_pid_steering_macros.svh"

module line_sensor_pid_steering #(
	parameter int DUTY_BITS = lsps_pkg::DUTY_BITS_DEF,
	parameter int SUM_BITS  = lsps_pkg::SUM_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [lsps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsps_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lsps_pkg::PAT_W-1:0]            sensor_pattern,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [DUTY_BITS-1:0]                  right_duty,
	output logic [DUTY_BITS-1:0]                  left_duty,
	output logic signed [lsps_pkg::ERR_W-1:0]     position_error,
	output logic signed [lsps_pkg::DRIVE_W-1:0]   drive_value,
	output logic                                  clamped
);

	localparam int ERR_W = lsps_pkg::ERR_W;
	localparam int FRAC  = lsps_pkg::FRAC_BITS;
	localparam int DRV_W = lsps_pkg::DRIVE_W;
	localparam int PD_W  = DRV_W;
	localparam int IPW   = SUM_BITS + lsps_pkg::GI_W + 1;
	localparam int TW    = ((PD_W + FRAC > IPW) ? PD_W + FRAC : IPW) + 1;
	localparam int DW    = TW - FRAC;
	localparam int VW    = (DUTY_BITS + 2 > DRV_W + 2) ? DUTY_BITS + 2 : DRV_W + 2;

	localparam logic signed [SUM_BITS:0] SUM_MAX =
		(SUM_BITS+1)'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_BITS:0] SUM_MIN = (SUM_BITS+1)'(-SUM_MAX - 1);
	localparam logic signed [TW-1:0]     RND     = TW'((64'sd1 <<< FRAC) - 64'sd1);
	localparam logic signed [DW-1:0]     DMAX    = DW'(lsps_pkg::DRIVE_MAX);
	localparam logic signed [DW-1:0]     DMIN    = DW'(lsps_pkg::DRIVE_MIN);
	localparam logic signed [VW-1:0]     DTOP    = VW'((64'sd1 <<< DUTY_BITS) - 64'sd1);

	// configuration
	logic [lsps_pkg::GP_W-1:0]   gain_prop_q;
	logic [lsps_pkg::GI_W-1:0]   gain_int_q24_q;
	logic [lsps_pkg::GD_W-1:0]   gain_deriv_q;
	logic [lsps_pkg::BASE_W-1:0] base_speed_q;

	// controller state
	lsps_pkg::err_t             last_error_q;
	logic signed [SUM_BITS-1:0] error_sum_q;

	// pipeline
	logic s1_valid_q, s2_valid_q, out_valid_q;
	lsps_pkg::err_t             err_s1, err_s2;
	logic signed [ERR_W:0]      delta_s1;
	logic signed [SUM_BITS-1:0] sum_s1;
	logic signed [PD_W-1:0]     pd_s2;
	logic signed [IPW-1:0]      ip_s2;

	logic [DUTY_BITS-1:0]    right_q, left_q;
	lsps_pkg::err_t          err_q;
	logic signed [DRV_W-1:0] drive_q;
	logic                    clamped_q;

	logic out_free, s2_free, s1_free, s1_adv, s2_adv, in_acc;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_adv   = s2_valid_q && out_free;
	assign s2_free  = !s2_valid_q || out_free;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s1_free  = !s1_valid_q || s2_free;
	assign in_stall = !s1_free;
	assign in_acc   = in_valid && s1_free;

	// stage 1: decode and integrate
	lsps_pkg::pos_t             dec;
	lsps_pkg::err_t             e_in;
	logic signed [ERR_W:0]      delta_c;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_c;

	assign dec      = lsps_pkg::decode_pattern(sensor_pattern);
	assign e_in     = dec.hit ? dec.err : last_error_q;
	assign delta_c  = (ERR_W+1)'(e_in) - (ERR_W+1)'(last_error_q);
	assign sum_wide = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(e_in);

	always_comb begin
		if (sum_wide > SUM_MAX) begin
			sum_c = SUM_MAX[SUM_BITS-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_c = SUM_MIN[SUM_BITS-1:0];
		end else begin
			sum_c = sum_wide[SUM_BITS-1:0];
		end
	end

	// stage 2: products
	logic signed [PD_W-1:0] p_term;
	logic signed [PD_W:0]   d_term;
	logic signed [PD_W:0]   pd_c;
	logic signed [IPW-1:0]  ip_c;

	assign p_term = $signed({1'b0, gain_prop_q}) * err_s1;
	assign d_term = $signed({1'b0, gain_deriv_q}) * delta_s1;
	assign pd_c   = (PD_W+1)'(p_term) + d_term;
	assign ip_c   = $signed({1'b0, gain_int_q24_q}) * sum_s1;

	// stage 3: sum, truncate toward zero, saturate, clamp
	logic signed [TW-1:0]    total, total_adj;
	logic signed [DW-1:0]    drive_full;
	logic signed [DRV_W-1:0] drive_c;
	logic signed [VW-1:0]    vr, vl;
	logic [DUTY_BITS-1:0]    right_c, left_c;
	logic                    hit_r, hit_l;

	assign total      = (TW'(pd_s2) <<< FRAC) + TW'(ip_s2);
	assign total_adj  = total[TW-1] ? total + RND : total;
	assign drive_full = DW'(total_adj >>> FRAC);

	always_comb begin
		if (drive_full > DMAX) begin
			drive_c = DMAX[DRV_W-1:0];
		end else if (drive_full < DMIN) begin
			drive_c = DMIN[DRV_W-1:0];
		end else begin
			drive_c = drive_full[DRV_W-1:0];
		end
	end

	assign vr = $signed(VW'(base_speed_q)) - VW'(drive_c);
	assign vl = $signed(VW'(base_speed_q)) + VW'(drive_c);

	always_comb begin
		hit_r   = 1'b0;
		right_c = vr[DUTY_BITS-1:0];
		if (vr < 0) begin
			hit_r   = 1'b1;
			right_c = '0;
		end else if (vr > DTOP) begin
			hit_r   = 1'b1;
			right_c = DTOP[DUTY_BITS-1:0];
		end
		hit_l  = 1'b0;
		left_c = vl[DUTY_BITS-1:0];
		if (vl < 0) begin
			hit_l  = 1'b1;
			left_c = '0;
		end else if (vl > DTOP) begin
			hit_l  = 1'b1;
			left_c = DTOP[DUTY_BITS-1:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q    <= lsps_pkg::GAIN_PROP_RST;
			gain_int_q24_q <= lsps_pkg::GAIN_INT_Q24_RST;
			gain_deriv_q   <= lsps_pkg::GAIN_DERIV_RST;
			base_speed_q   <= lsps_pkg::BASE_SPEED_RST;
			last_error_q   <= '0;
			error_sum_q    <= '0;
			s1_valid_q     <= 1'b0;
			s2_valid_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					lsps_pkg::CFG_GAIN_PROP:    gain_prop_q    <= cfg_data[lsps_pkg::GP_W-1:0];
					lsps_pkg::CFG_GAIN_INT_Q24: gain_int_q24_q <= cfg_data[lsps_pkg::GI_W-1:0];
					lsps_pkg::CFG_GAIN_DERIV:   gain_deriv_q   <= cfg_data[lsps_pkg::GD_W-1:0];
					lsps_pkg::CFG_BASE_SPEED:   base_speed_q   <= cfg_data[lsps_pkg::BASE_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				last_error_q <= e_in;
				error_sum_q  <= sum_c;
			end
			if (s1_free) begin
				s1_valid_q <= in_acc;
			end
			if (s2_free) begin
				s2_valid_q <= s1_adv;
			end
			if (out_free) begin
				out_valid_q <= s2_adv;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_s1   <= e_in;
			delta_s1 <= delta_c;
			sum_s1   <= sum_c;
		end
		if (s1_adv) begin
			err_s2 <= err_s1;
			pd_s2  <= pd_c[PD_W-1:0];
			ip_s2  <= ip_c;
		end
		if (s2_adv) begin
			right_q   <= right_c;
			left_q    <= left_c;
			err_q     <= err_s2;
			drive_q   <= drive_c;
			clamped_q <= hit_r || hit_l;
		end
	end

	assign out_valid      = out_valid_q;
	assign right_duty     = right_q;
	assign left_duty      = left_q;
	assign position_error = err_q;
	assign drive_value    = drive_q;
	assign clamped        = clamped_q;

	`LSPS_ASSERT_NXT(a_acc_fills_s1, in_acc, s1_valid_q, "accepted transaction lost at stage 1")
	`LSPS_ASSERT_NXT(a_unknown_holds, in_acc && !dec.hit, last_error_q == $past(last_error_q), "unknown pattern changed last error")
	`LSPS_ASSERT_IMP(a_stall_full, in_stall, s1_valid_q && s2_valid_q && out_valid_q, "input stalled with a free stage")
	`LSPS_ASSERT_IMP(a_err_range, out_valid, (position_error >= -4'sd4) && (position_error <= 4'sd4), "position error out of range")

endmodule
